// ===== hw/rtl/sdi_pkg.sv =====
// Package: phase encoding, command codes and card-type flags for the SD SPI initializer.
package sdi_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WAKE      = 4'd1,
        PH_DESEL     = 4'd2,
        PH_SELDUMMY  = 4'd3,
        PH_WAITRDY   = 4'd4,
        PH_TMO_DESEL = 4'd5,
        PH_PACKET    = 4'd6,
        PH_POLL      = 4'd7,
        PH_OCR       = 4'd8,
        PH_PAUSE     = 4'd9,
        PH_FINAL     = 4'd10
    } phase_t;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_XFER  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [5:0] CMD0  = 6'd0;
    localparam logic [5:0] CMD1  = 6'd1;
    localparam logic [5:0] CMD8  = 6'd8;
    localparam logic [5:0] CMD16 = 6'd16;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;

    localparam logic [3:0] TYPE_MMC   = 4'h1;
    localparam logic [3:0] TYPE_SD1   = 4'h2;
    localparam logic [3:0] TYPE_SD2   = 4'h4;
    localparam logic [3:0] TYPE_BLOCK = 4'h8;

    localparam int unsigned RESPONSE_POLL_BYTES = 10;

    localparam logic [1:0] REG_READY_TMO = 2'd0;
    localparam logic [1:0] REG_INIT_TMO  = 2'd1;
    localparam logic [1:0] REG_IDLE_TRY  = 2'd2;

    localparam logic [15:0] READY_TMO_RST = 16'd500;
    localparam logic [15:0] INIT_TMO_RST  = 16'd1000;
    localparam logic [3:0]  IDLE_TRY_RST  = 4'd5;

    // Result item handed from the sequencer to the output stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] tx_byte;
        logic       select_low;
        logic       finished;
        logic [3:0] card_type;
    } sdi_res_t;

endpackage

// ===== hw/rtl/sdi_seq.sv =====
// Sequencer: one state update per accepted transaction, result registered downstream.
module sdi_seq
    import sdi_pkg::*;
#(
    parameter int unsigned POLL_BYTES = RESPONSE_POLL_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [1:0]  op,
    input  logic [7:0]  rx,
    input  logic [15:0] ready_tmo,
    input  logic [15:0] init_tmo,
    input  logic [3:0]  idle_tries,
    output sdi_res_t    res
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic [3:0]  fidx_reg, fidx_next;
    logic [3:0]  poll_reg, poll_next;
    logic [3:0]  try_reg, try_next;
    logic [31:0] ocr_reg, ocr_next;
    logic [3:0]  type_reg, type_next;
    logic [15:0] itmr_reg, itmr_next;
    logic [15:0] rtmr_reg, rtmr_next;
    logic        app_reg, app_next;

    logic [5:0]  wcmd;
    logic [31:0] warg;
    logic [3:0]  pk_idx;
    logic [7:0]  pk_byte;
    logic        time_left;

    assign wcmd      = app_reg ? CMD55 : cmd_reg;
    assign warg      = app_reg ? 32'd0 : arg_reg;
    assign time_left = itmr_reg < init_tmo;

    always_comb begin
        unique case (pk_idx)
            4'd0:    pk_byte = {2'b01, wcmd};
            4'd1:    pk_byte = warg[31:24];
            4'd2:    pk_byte = warg[23:16];
            4'd3:    pk_byte = warg[15:8];
            4'd4:    pk_byte = warg[7:0];
            default: pk_byte = (wcmd == CMD0) ? 8'h95 : (wcmd == CMD8) ? 8'h87 : 8'h01;
        endcase
    end

    always_comb begin
        logic [7:0] r;
        logic       done;
        logic [31:0] ocr_sh;
        phase_next = phase_reg; cmd_next = cmd_reg; arg_next = arg_reg;
        fidx_next = fidx_reg; poll_next = poll_reg; try_next = try_reg;
        ocr_next = ocr_reg; type_next = type_reg; itmr_next = itmr_reg;
        rtmr_next = rtmr_reg; app_next = app_reg;
        res = '0;
        pk_idx = 4'd0;
        r = 8'hFF;
        done = 1'b0;
        ocr_sh = {ocr_reg[23:0], rx};

        if (step) begin
            unique case (op)
                OP_START: begin
                    phase_next = PH_WAKE; fidx_next = '0; poll_next = '0; try_next = '0;
                    ocr_next = '0; type_next = '0; cmd_next = CMD0; arg_next = '0;
                    itmr_next = '0; rtmr_next = '0; app_next = 1'b0;
                    res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                end
                OP_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        if (itmr_reg != 16'hFFFF) itmr_next = itmr_reg + 16'd1;
                        if (rtmr_reg != 16'hFFFF) rtmr_next = rtmr_reg + 16'd1;
                        if (phase_reg == PH_PAUSE) begin
                            if (try_reg >= idle_tries) begin
                                type_next = '0; phase_next = PH_FINAL;
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                            end else begin
                                cmd_next = CMD0; arg_next = '0; app_next = 1'b0;
                                phase_next = PH_DESEL;
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                            end
                        end
                    end
                end
                OP_XFER: begin
                    unique case (phase_reg)
                        PH_WAKE: begin
                            fidx_next = fidx_reg + 4'd1;
                            if (fidx_reg + 4'd1 < 4'd10) begin
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                            end else begin
                                try_next = '0;
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                                if (idle_tries == 4'd0) begin
                                    type_next = '0; phase_next = PH_FINAL;
                                end else begin
                                    cmd_next = CMD0; arg_next = '0; app_next = 1'b0;
                                    phase_next = PH_DESEL;
                                end
                            end
                        end
                        PH_DESEL: begin
                            phase_next = PH_SELDUMMY;
                            res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1, default: '0};
                        end
                        PH_SELDUMMY: begin
                            phase_next = PH_WAITRDY; rtmr_next = '0;
                            res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1, default: '0};
                        end
                        PH_WAITRDY: begin
                            if (rx == 8'hFF) begin
                                phase_next = PH_PACKET; fidx_next = '0; pk_idx = 4'd0;
                                res = '{valid: 1'b1, tx_byte: pk_byte, select_low: 1'b1,
                                        default: '0};
                            end else if (rtmr_reg < ready_tmo) begin
                                res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1,
                                        default: '0};
                            end else begin
                                phase_next = PH_TMO_DESEL;
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                            end
                        end
                        PH_TMO_DESEL: begin
                            done = 1'b1; r = 8'hFF;
                        end
                        PH_PACKET: begin
                            fidx_next = fidx_reg + 4'd1;
                            if (fidx_reg + 4'd1 <= 4'd5) begin
                                pk_idx = fidx_reg + 4'd1;
                                res = '{valid: 1'b1, tx_byte: pk_byte, select_low: 1'b1,
                                        default: '0};
                            end else begin
                                phase_next = PH_POLL; poll_next = POLL_BYTES[3:0];
                                res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1,
                                        default: '0};
                            end
                        end
                        PH_POLL: begin
                            if (rx[7] && poll_reg > 4'd1) begin
                                poll_next = poll_reg - 4'd1;
                                res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1,
                                        default: '0};
                            end else begin
                                done = 1'b1; r = rx;
                            end
                        end
                        PH_OCR: begin
                            ocr_next = ocr_sh;
                            fidx_next = fidx_reg + 4'd1;
                            if (fidx_reg + 4'd1 < 4'd4) begin
                                res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1,
                                        default: '0};
                            end else if (cmd_reg == CMD8) begin
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                                if (ocr_sh[15:0] == 16'h01AA && time_left) begin
                                    cmd_next = CMD41; arg_next = 32'h4000_0000;
                                    app_next = 1'b1; phase_next = PH_DESEL;
                                end else begin
                                    type_next = '0; phase_next = PH_FINAL;
                                end
                            end else begin
                                type_next = ocr_sh[30] ? (TYPE_SD2 | TYPE_BLOCK) : TYPE_SD2;
                                phase_next = PH_FINAL;
                                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
                            end
                        end
                        PH_FINAL: begin
                            phase_next = PH_IDLE;
                            res = '{valid: 1'b1, finished: 1'b1, card_type: type_reg,
                                    default: '0};
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        // Command completion: decide the next command from the answer.
        if (done) begin
            logic       go;      // start a new command
            logic       fail;
            logic       fin;
            logic       ocr;
            logic       resend;
            logic [5:0] ncmd;
            logic [31:0] narg;
            go = 1'b0; fail = 1'b0; fin = 1'b0; ocr = 1'b0; resend = 1'b0;
            ncmd = CMD0; narg = '0;
            if (app_reg && r <= 8'd1) begin
                resend = 1'b1;
            end else begin
                unique case (cmd_reg)
                    CMD0: begin
                        if (r == 8'd1) begin
                            itmr_next = '0; go = 1'b1; ncmd = CMD8; narg = 32'h1AA;
                        end else begin
                            if (try_reg < 4'd15) try_next = try_reg + 4'd1;
                            if (r != 8'hFF) phase_next = PH_PAUSE;
                            else if (((try_reg < 4'd15) ? try_reg + 4'd1 : try_reg)
                                     >= idle_tries) fail = 1'b1;
                            else go = 1'b1;
                        end
                    end
                    CMD8: begin
                        if (r == 8'd1) ocr = 1'b1;
                        else begin go = 1'b1; ncmd = CMD41; end
                    end
                    CMD41, CMD1: begin
                        if (cmd_reg == CMD41 && arg_reg[30]) begin
                            if (!time_left) fail = 1'b1;
                            else if (r != 8'd0) begin
                                go = 1'b1; ncmd = CMD41; narg = 32'h4000_0000;
                            end else begin go = 1'b1; ncmd = CMD58; end
                        end else if (cmd_reg == CMD41 && type_reg == 4'd0) begin
                            type_next = (r <= 8'd1) ? TYPE_SD1 : TYPE_MMC;
                            if (!time_left) fail = 1'b1;
                            else begin
                                go = 1'b1; ncmd = (r <= 8'd1) ? CMD41 : CMD1;
                            end
                        end else begin
                            if (!time_left) fail = 1'b1;
                            else if (r != 8'd0) begin
                                go = 1'b1; ncmd = (type_reg == TYPE_SD1) ? CMD41 : CMD1;
                            end else begin go = 1'b1; ncmd = CMD16; narg = 32'd512; end
                        end
                    end
                    CMD16: begin
                        if (r != 8'd0) fail = 1'b1; else fin = 1'b1;
                    end
                    CMD58: begin
                        if (r == 8'd0) ocr = 1'b1; else fail = 1'b1;
                    end
                    default: fail = 1'b1;
                endcase
            end
            app_next = 1'b0;
            if (resend) begin
                phase_next = PH_DESEL;
                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
            end else if (go) begin
                cmd_next = ncmd; arg_next = narg; app_next = (ncmd == CMD41);
                phase_next = PH_DESEL;
                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
            end else if (fail || fin) begin
                if (fail) type_next = '0;
                phase_next = PH_FINAL;
                res = '{valid: 1'b1, tx_byte: 8'hFF, default: '0};
            end else if (ocr) begin
                phase_next = PH_OCR; fidx_next = '0; ocr_next = '0;
                res = '{valid: 1'b1, tx_byte: 8'hFF, select_low: 1'b1, default: '0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; cmd_reg <= '0; arg_reg <= '0; fidx_reg <= '0;
            poll_reg <= '0; try_reg <= '0; ocr_reg <= '0; type_reg <= '0;
            itmr_reg <= '0; rtmr_reg <= '0; app_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; cmd_reg <= cmd_next; arg_reg <= arg_next;
            fidx_reg <= fidx_next; poll_reg <= poll_next; try_reg <= try_next;
            ocr_reg <= ocr_next; type_reg <= type_next; itmr_reg <= itmr_next;
            rtmr_reg <= rtmr_next; app_reg <= app_next;
        end
    end

    // Timers only move on an accepted transaction.
    a_itmr: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> itmr_reg == $past(itmr_reg))
        else $error("init timer moved without transaction");
    a_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_POLL |-> poll_reg != '0)
        else $error("poll count empty while polling");
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE && step && op != OP_START |-> !res.valid)
        else $error("result while idle");

endmodule

// ===== hw/rtl/sd_spi_card_init.sv =====
// Top level: SD card SPI-mode initializer with APB registers and registered result.
// One input transaction (start, byte exchange done, or 1 ms tick) is taken per clock while
// s_ready is high; the state update is a single combinational step into the state
// registers, and the result (next byte with chip-select level, or the final card-type
// report) lands in a one-entry output register. Input ready is high whenever that register
// is empty or being drained, so throughput is one transaction per cycle unless the output
// stalls. Card type flags: 1 MMC, 2 SDv1, 4 SDv2, 8 block addressing; 0 means failure.
// Registers at 0x0 ready_timeout_ms, 0x4 init_timeout_ms, 0x8 idle_tries.
module sd_spi_card_init
    import sdi_pkg::*;
#(
    parameter int unsigned POLL_BYTES = RESPONSE_POLL_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_select_low,
    output logic        m_finished,
    output logic [3:0]  m_card_type,
    output logic        m_ready_res,
    output logic        m_fast_clock,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] rdy_tmo_reg, ini_tmo_reg;
    logic [3:0]  tries_reg;
    logic        step;
    sdi_res_t    res;
    sdi_res_t    out_reg;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdy_tmo_reg <= READY_TMO_RST; ini_tmo_reg <= INIT_TMO_RST;
            tries_reg <= IDLE_TRY_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[3:2] == REG_READY_TMO) rdy_tmo_reg <= pwdata[15:0];
            if (paddr[3:2] == REG_INIT_TMO)  ini_tmo_reg <= pwdata[15:0];
            if (paddr[3:2] == REG_IDLE_TRY)  tries_reg   <= pwdata[3:0];
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            REG_READY_TMO: prdata = {16'd0, rdy_tmo_reg};
            REG_INIT_TMO:  prdata = {16'd0, ini_tmo_reg};
            REG_IDLE_TRY:  prdata = {28'd0, tries_reg};
            default:       prdata = '0;
        endcase
    end

    assign s_ready = !out_reg.valid || m_ready;
    assign step    = s_valid && s_ready;

    sdi_seq #(.POLL_BYTES(POLL_BYTES)) u_seq (
        .aclk, .aresetn, .step, .op(s_operation), .rx(s_rx_byte),
        .ready_tmo(rdy_tmo_reg), .init_tmo(ini_tmo_reg), .idle_tries(tries_reg), .res
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) out_reg.valid <= 1'b0;
        else if (s_ready) out_reg.valid <= res.valid;
        if (s_ready) begin
            out_reg.tx_byte <= res.tx_byte; out_reg.select_low <= res.select_low;
            out_reg.finished <= res.finished; out_reg.card_type <= res.card_type;
        end
    end

    assign m_valid      = out_reg.valid;
    assign m_tx_byte    = out_reg.tx_byte;
    assign m_select_low = out_reg.select_low;
    assign m_finished   = out_reg.finished;
    assign m_card_type  = out_reg.card_type;
    assign m_ready_res  = out_reg.finished && (out_reg.card_type != 4'd0);
    assign m_fast_clock = m_ready_res;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte))
        else $error("result dropped while stalled");
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> !m_select_low && m_tx_byte == 8'd0)
        else $error("final result carries a byte");
    a_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_finished |-> m_card_type == 4'd0)
        else $error("byte result carries card type");

endmodule

// ===== bench/sd_spi_card_init_tb.sv =====
// Testbench for the SD card SPI-mode initializer: directed table, then card-like random traffic.
module sd_spi_card_init_tb
    import sdi_pkg::*;
();

    // One result transaction as seen on the m_ side.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       select_low;
        logic       finished;
        logic [3:0] card_type;
        logic       ready_res;
        logic       fast_clock;
    } card_res_t;

    // Directed stimulus row; when typed is set, the expectation comes from the row itself.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx;
        logic       typed;
        logic       has_res;
        card_res_t  res;
    } stim_row_t;

    localparam logic [1:0] OP_NONE = 2'd3;    // unused code, block must ignore it
    localparam card_res_t  BYTE_FF_CS_HIGH = '{8'hFF, 1'b0, 1'b0, 4'h0, 1'b0, 1'b0};
    localparam card_res_t  NO_RES = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_TICK;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_select_low;
    logic        m_finished;
    logic [3:0]  m_card_type;
    logic        m_ready_res;
    logic        m_fast_clock;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    sd_spi_card_init DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_tx_byte(m_tx_byte),
        .m_select_low(m_select_low), .m_finished(m_finished),
        .m_card_type(m_card_type), .m_ready_res(m_ready_res),
        .m_fast_clock(m_fast_clock),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    card_res_t expected_bytes[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // ---------------------------------------------------------------
    // Card-init predictor: private copy of state and registers.
    // ---------------------------------------------------------------
    logic [15:0] cfg_ready_tmo, cfg_init_tmo;
    logic [3:0]  cfg_tries;

    phase_t      seq_phase;
    logic [5:0]  cur_cmd;
    logic [31:0] cur_arg;
    logic [3:0]  frame_idx, polls_left, cmd0_tries;
    logic [7:0]  last_answer;
    logic [31:0] ocr_shift;
    logic [3:0]  card_flags;
    logic [15:0] init_ms, busy_ms;
    logic        acmd_prefix;

    logic        out_has;
    card_res_t   out_res;

    function automatic void emit(logic [7:0] tx, logic sel);
        out_has = 1'b1;
        out_res = '{tx, sel, 1'b0, 4'h0, 1'b0, 1'b0};
    endfunction

    function automatic logic [7:0] frame_byte(logic [3:0] k);
        logic [5:0]  c;
        logic [31:0] a;
        c = acmd_prefix ? CMD55 : cur_cmd;
        a = acmd_prefix ? 32'h0 : cur_arg;
        if (k == 0) return 8'h40 | {2'b00, c};
        if (k <= 4) return 8'(a >> (8 * (4 - k)));
        if (c == CMD0) return 8'h95;
        if (c == CMD8) return 8'h87;
        return 8'h01;
    endfunction

    function automatic void open_frame();
        seq_phase = PH_DESEL;
        emit(8'hFF, 1'b0);
    endfunction

    function automatic void issue(logic [5:0] code, logic [31:0] arg);
        cur_cmd = code;
        cur_arg = arg;
        acmd_prefix = (code == CMD41);
        open_frame();
    endfunction

    function automatic void finish_seq();
        seq_phase = PH_FINAL;
        emit(8'hFF, 1'b0);
    endfunction

    function automatic void abort_seq();
        card_flags = 4'h0;
        finish_seq();
    endfunction

    function automatic void retry_cmd0();
        if (cmd0_tries >= cfg_tries) abort_seq();
        else issue(CMD0, 32'h0);
    endfunction

    function automatic void init_loop_v1();
        if (init_ms < cfg_init_tmo) issue(card_flags == TYPE_SD1 ? CMD41 : CMD1, 32'h0);
        else abort_seq();
    endfunction

    function automatic void answer_v1(logic [7:0] res);
        if (res != 0) init_loop_v1();
        else if (init_ms < cfg_init_tmo) issue(CMD16, 32'd512);
        else abort_seq();
    endfunction

    function automatic void begin_ocr_read();
        seq_phase = PH_OCR;
        frame_idx = 0;
        ocr_shift = 0;
        emit(8'hFF, 1'b1);
    endfunction

    function automatic void command_answered(logic [7:0] res);
        last_answer = res;
        if (acmd_prefix) begin
            acmd_prefix = 1'b0;
            if (res <= 1) begin
                open_frame();
                return;
            end
        end
        case (cur_cmd)
            CMD0: begin
                if (res == 1) begin
                    init_ms = 0;
                    issue(CMD8, 32'h1AA);
                end else begin
                    if (cmd0_tries < 15) cmd0_tries++;
                    if (res != 8'hFF) seq_phase = PH_PAUSE;
                    else retry_cmd0();
                end
            end
            CMD8: begin
                if (res == 1) begin_ocr_read();
                else issue(CMD41, 32'h0);
            end
            CMD41: begin
                if (cur_arg[30]) begin
                    if (res != 0) begin
                        if (init_ms < cfg_init_tmo) issue(CMD41, 32'h4000_0000);
                        else abort_seq();
                    end else if (init_ms < cfg_init_tmo) issue(CMD58, 32'h0);
                    else abort_seq();
                end else if (card_flags == 0) begin
                    card_flags = (res <= 1) ? TYPE_SD1 : TYPE_MMC;
                    init_loop_v1();
                end else begin
                    answer_v1(res);
                end
            end
            CMD1: answer_v1(res);
            CMD16: begin
                if (res != 0) abort_seq();
                else finish_seq();
            end
            CMD58: begin
                if (res == 0) begin_ocr_read();
                else abort_seq();
            end
            default: abort_seq();
        endcase
    endfunction

    function automatic void byte_done(logic [7:0] rx);
        case (seq_phase)
            PH_WAKE: begin
                frame_idx++;
                if (frame_idx < 10) emit(8'hFF, 1'b0);
                else begin
                    cmd0_tries = 0;
                    retry_cmd0();
                end
            end
            PH_DESEL: begin
                seq_phase = PH_SELDUMMY;
                emit(8'hFF, 1'b1);
            end
            PH_SELDUMMY: begin
                seq_phase = PH_WAITRDY;
                busy_ms = 0;
                emit(8'hFF, 1'b1);
            end
            PH_WAITRDY: begin
                if (rx == 8'hFF) begin
                    seq_phase = PH_PACKET;
                    frame_idx = 0;
                    emit(frame_byte(0), 1'b1);
                end else if (busy_ms < cfg_ready_tmo) emit(8'hFF, 1'b1);
                else begin
                    seq_phase = PH_TMO_DESEL;
                    emit(8'hFF, 1'b0);
                end
            end
            PH_TMO_DESEL: command_answered(8'hFF);
            PH_PACKET: begin
                frame_idx++;
                if (frame_idx <= 5) emit(frame_byte(frame_idx), 1'b1);
                else begin
                    seq_phase = PH_POLL;
                    polls_left = 4'(RESPONSE_POLL_BYTES);
                    emit(8'hFF, 1'b1);
                end
            end
            PH_POLL: begin
                if (rx[7] && polls_left > 1) begin
                    polls_left--;
                    emit(8'hFF, 1'b1);
                end else command_answered(rx);
            end
            PH_OCR: begin
                ocr_shift = {ocr_shift[23:0], rx};
                frame_idx++;
                if (frame_idx < 4) emit(8'hFF, 1'b1);
                else if (cur_cmd == CMD8) begin
                    if (ocr_shift[15:0] == 16'h1AA) begin
                        if (init_ms < cfg_init_tmo) issue(CMD41, 32'h4000_0000);
                        else abort_seq();
                    end else abort_seq();
                end else begin
                    card_flags = ocr_shift[30] ? (TYPE_SD2 | TYPE_BLOCK) : TYPE_SD2;
                    finish_seq();
                end
            end
            PH_FINAL: begin
                seq_phase = PH_IDLE;
                out_has = 1'b1;
                out_res = '{8'h00, 1'b0, 1'b1, card_flags, card_flags != 0, card_flags != 0};
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_card_step(logic [1:0] op, logic [7:0] rx);
        out_has = 1'b0;
        out_res = NO_RES;
        if (op == OP_START) begin
            seq_phase = PH_WAKE;
            frame_idx = 0; polls_left = 0; cmd0_tries = 0; last_answer = 8'hFF;
            ocr_shift = 0; card_flags = 0; cur_cmd = CMD0; cur_arg = 0;
            init_ms = 0; busy_ms = 0; acmd_prefix = 1'b0;
            emit(8'hFF, 1'b0);
        end else if (op == OP_XFER) begin
            byte_done(rx);
        end else if (op == OP_TICK && seq_phase != PH_IDLE) begin
            if (init_ms != 16'hFFFF) init_ms++;
            if (busy_ms != 16'hFFFF) busy_ms++;
            if (seq_phase == PH_PAUSE) retry_cmd0();
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every m_ transaction against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        card_res_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_tx_byte, m_select_low, m_finished, m_card_type, m_ready_res,
                    m_fast_clock};
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result %h, nothing expected", $time, got);
            end else begin
                want = expected_bytes.pop_front();
                if (got.tx_byte != want.tx_byte)
                    $display("%0t: tx_byte exp %h got %h", $time, want.tx_byte, got.tx_byte);
                if (got.select_low != want.select_low)
                    $display("%0t: select_low exp %b got %b", $time, want.select_low,
                             got.select_low);
                if (got.finished != want.finished)
                    $display("%0t: finished exp %b got %b", $time, want.finished,
                             got.finished);
                if (got.card_type != want.card_type)
                    $display("%0t: card_type exp %h got %h", $time, want.card_type,
                             got.card_type);
                if (got.ready_res != want.ready_res)
                    $display("%0t: ready_res exp %b got %b", $time, want.ready_res,
                             got.ready_res);
                if (got.fast_clock != want.fast_clock)
                    $display("%0t: fast_clock exp %b got %b", $time, want.fast_clock,
                             got.fast_clock);
                if (got != want) mismatches++;
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // ---------------------------------------------------------------
    // Drivers. All called right after a falling edge.
    // ---------------------------------------------------------------
    task automatic send_txn(input logic [1:0] op, input logic [7:0] rx,
                            input logic typed, input logic has_res, input card_res_t res);
        s_valid = 1'b1;
        s_operation = op;
        s_rx_byte = rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_card_step(op, rx);
        if (typed) begin
            if (has_res) expected_bytes.push_back(res);
        end else if (out_has) expected_bytes.push_back(out_res);
        @(negedge aclk);
        // random sender gap with s_valid low
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (expected_bytes.size() != 0) @(negedge aclk);
        // let the registered result and any no-result transaction settle too
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_READY_TMO: cfg_ready_tmo = value[15:0];
            REG_INIT_TMO:  cfg_init_tmo = value[15:0];
            REG_IDLE_TRY:  cfg_tries = value[3:0];
            default: ;
        endcase
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Card-like answer for the current exchange so that sequences get deep.
    function automatic logic [7:0] card_answer();
        int r;
        r = $urandom_range(99);
        case (seq_phase)
            PH_WAITRDY: return (r < 80) ? 8'hFF : 8'($urandom_range(255));
            PH_POLL: begin
                if (r < 25) return 8'h80 | 8'($urandom_range(127));
                if (acmd_prefix) return (r < 80) ? 8'h01 : 8'($urandom_range(255));
                case (cur_cmd)
                    CMD0:  return (r < 75) ? 8'h01 : (r < 88) ? 8'hFF
                                                             : 8'($urandom_range(255));
                    CMD8:  return (r < 65) ? 8'h01 : (r < 90) ? 8'h05
                                                             : 8'($urandom_range(255));
                    CMD41, CMD1: return (r < 50) ? 8'h00 : (r < 85) ? 8'h01
                                                             : 8'($urandom_range(255));
                    default: return (r < 85) ? 8'h00 : 8'($urandom_range(255));
                endcase
            end
            PH_OCR: begin
                if (frame_idx == 2 && r < 85) return 8'h01;
                if (frame_idx == 3 && r < 85) return 8'hAA;
                return 8'($urandom_range(255));
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic random_txn();
        int r;
        logic [1:0] op;
        logic [7:0] rx;
        r = $urandom_range(99);
        rx = 8'($urandom_range(255));
        if (r < 1) op = OP_NONE;
        else if (r < 2) op = OP_START;
        else if (seq_phase == PH_IDLE) op = (r < 12) ? OP_XFER : OP_START;
        else if (seq_phase == PH_PAUSE) op = (r < 80) ? OP_TICK : OP_XFER;
        else if (r < 9) op = OP_TICK;
        else begin
            op = OP_XFER;
            rx = card_answer();
        end
        send_txn(op, rx, 1'b0, 1'b0, NO_RES);
    endtask

    // ---------------------------------------------------------------
    // Directed table: ignored codes, restart, early frame bytes.
    // ---------------------------------------------------------------
    stim_row_t directed_rows[] = '{
        '{OP_NONE,  8'hFF, 1'b1, 1'b0, NO_RES},           // unknown code, idle
        '{OP_XFER,  8'h00, 1'b1, 1'b0, NO_RES},           // exchange while idle
        '{OP_TICK,  8'hFF, 1'b1, 1'b0, NO_RES},           // tick while idle
        '{OP_START, 8'h00, 1'b1, 1'b1, BYTE_FF_CS_HIGH},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'h00, 1'b0, 1'b0, NO_RES},
        '{OP_NONE,  8'h00, 1'b1, 1'b0, NO_RES},           // unknown code, running
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_TICK,  8'h00, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},           // ninth idle byte
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},           // tenth idle byte -> CMD0
        '{OP_XFER,  8'h00, 1'b0, 1'b0, NO_RES},           // deselect done
        '{OP_XFER,  8'h00, 1'b0, 1'b0, NO_RES},           // dummy done, busy poll
        '{OP_XFER,  8'hFF, 1'b0, 1'b0, NO_RES},           // ready: first packet byte
        '{OP_XFER,  8'h00, 1'b0, 1'b0, NO_RES},
        '{OP_START, 8'hFF, 1'b1, 1'b1, BYTE_FF_CS_HIGH}   // restart mid-command
    };

    // Register settings for the random phases: {ready_tmo, init_tmo, idle_tries}.
    logic [47:0] reg_sets[] = '{
        {16'd500,   16'd1000,  16'd5},          // reset values, rewritten
        {16'd1,     16'd1,     16'd1},
        {16'd65535, 16'd65535, 16'd15},
        {16'd0,     16'd0,     16'd0},          // always expired, no CMD0 at all
        {16'd2,     16'd12,    16'd2},
        {16'd3,     16'd40,    16'd3}
    };

    initial begin
        logic [15:0] rt, it;
        logic [3:0]  tr;
        cfg_ready_tmo = READY_TMO_RST;
        cfg_init_tmo = INIT_TMO_RST;
        cfg_tries = IDLE_TRY_RST;
        predict_card_step(OP_NONE, 8'h00);
        seq_phase = PH_IDLE;
        cur_cmd = CMD0; cur_arg = 0; frame_idx = 0; polls_left = 0; cmd0_tries = 0;
        last_answer = 8'hFF; ocr_shift = 0; card_flags = 0; init_ms = 0; busy_ms = 0;
        acmd_prefix = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_txn(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].typed,
                     directed_rows[i].has_res, directed_rows[i].res);
        drain_results();

        // Random phases; idle mode rotates every three register settings.
        for (int p = 0; p < reg_sets.size() + 1; p++) begin
            if (p < reg_sets.size()) begin
                rt = reg_sets[p][47:32];
                it = reg_sets[p][31:16];
                tr = reg_sets[p][3:0];
            end else begin
                rt = 16'($urandom_range(1, 6));
                it = 16'($urandom_range(1, 60));
                tr = 4'($urandom_range(1, 15));
            end
            apb_write(REG_READY_TMO, {16'($urandom_range(65535)), rt});
            apb_write(REG_INIT_TMO, {16'h0, it});
            apb_write(REG_IDLE_TRY, {28'h0, tr});
            case (p / 3)
                0: begin send_idle_pct = 32; recv_idle_pct = 53; end
                1: begin send_idle_pct = 53; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < 280; n++) begin
                random_txn();
                // hold the sender until the block has answered everything
                if (p == 1 && n == 140) begin
                    s_valid = 1'b0;
                    while (expected_bytes.size() != 0) @(negedge aclk);
                end
            end
            drain_results();
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
